### rtl/best_fit_block_allocator_top_defines.svh
// Assertion macros for the best-fit block allocator.
`ifndef BEST_FIT_BLOCK_ALLOCATOR_TOP_DEFINES_SVH
`define BEST_FIT_BLOCK_ALLOCATOR_TOP_DEFINES_SVH

// Condition must hold at every clock edge out of reset.
`define BFA_ASSERT_ALWAYS(label, cond, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (cond)) else $error(msg);

// Antecedent implies consequent in the same cycle.
`define BFA_ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Antecedent implies consequent in the next cycle.
`define BFA_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

### rtl/bfa_pkg.sv
// Shared types and constants of the best-fit block allocator.
package bfa_pkg;

  localparam int unsigned PAGES_DEF        = 16;
  localparam int unsigned SLOTS_DEF        = 64;
  localparam int unsigned HEADER_BYTES_DEF = 16;
  localparam int unsigned PAGE_BYTES       = 4096;
  localparam int unsigned PAGE_SHIFT       = 12;
  localparam int unsigned ADDR_W           = 16;
  localparam int unsigned SIZE_W           = 12;
  localparam int unsigned STORE_DEPTH      = 8192;
  localparam int unsigned STORE_AW         = 13;
  localparam int unsigned LIMIT_W          = 5;
  localparam logic [LIMIT_W-1:0] LIMIT_RST = 5'd16;

  localparam logic OP_ALLOC = 1'b0;
  localparam logic OP_FREE  = 1'b1;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_NO_PAGE  = 2'd1,
    ST_TBL_FULL = 2'd2
  } status_e;

  typedef struct packed {
    logic [ADDR_W-1:0] hdr;
    logic [SIZE_W-1:0] size;
  } entry_t;

  typedef struct packed {
    logic              found;
    logic [SIZE_W-1:0] size;
    logic [ADDR_W-1:0] hdr;
  } cand_t;

  typedef struct packed {
    logic remove;
    logic push;
  } cell_ctrl_t;

endpackage

### rtl/bfa_ram.sv
// Generic single-port RAM with registered read.
module bfa_ram #(
  parameter int unsigned WIDTH = 12,
  parameter int unsigned DEPTH = 8192
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] addr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    rdata_q <= mem_q[addr_i];
  end

  assign rdata_o = rdata_q;

endmodule

### rtl/bfa_cell.sv
// One free-slot cell: holds an entry and passes the best-fit candidate on.
module bfa_cell import bfa_pkg::*; #(
  parameter int unsigned SLOTS = SLOTS_DEF,
  parameter int unsigned IDX   = 0
) (
  input  logic                       clk_i,
  input  cell_ctrl_t                 ctrl_i,
  input  logic [$clog2(SLOTS)-1:0]   rm_idx_i,
  input  logic [$clog2(SLOTS+1)-1:0] count_i,
  input  entry_t                     push_i,
  input  entry_t                     nbr_i,
  input  logic [SIZE_W:0]            req_i,
  input  cand_t                      cand_i,
  input  logic [$clog2(SLOTS)-1:0]   cidx_i,
  output entry_t                     entry_o,
  output cand_t                      cand_o,
  output logic [$clog2(SLOTS)-1:0]   cidx_o
);

  localparam int unsigned IW = $clog2(SLOTS);
  localparam int unsigned CW = $clog2(SLOTS+1);

  entry_t         entry_q;
  cand_t          cand_q;
  logic [IW-1:0]  cidx_q;
  logic           valid;
  logic           take;

  assign valid = CW'(IDX) < count_i;
  // <= prefers the later (newer) entry on equal sizes
  assign take  = valid && ({1'b0, entry_q.size} >= req_i) &&
                 (!cand_i.found || entry_q.size <= cand_i.size);

  always_ff @(posedge clk_i) begin
    if (take) begin
      cand_q <= '{found: 1'b1, size: entry_q.size, hdr: entry_q.hdr};
      cidx_q <= IW'(IDX);
    end else begin
      cand_q <= cand_i;
      cidx_q <= cidx_i;
    end
    if (ctrl_i.remove && (IW'(IDX) >= rm_idx_i)) begin
      entry_q <= nbr_i;
    end else if (ctrl_i.push && (CW'(IDX) == count_i)) begin
      entry_q <= push_i;
    end
  end

  assign entry_o = entry_q;
  assign cand_o  = cand_q;
  assign cidx_o  = cidx_q;

endmodule

### rtl/best_fit_block_allocator_top.sv
// Best-fit block allocator: slot cell chain, size store and sequencer.
// Allocate: the request ripples down the slot cell chain in S_SCAN, then S_PICK and S_PLACE;
// a failed allocate goes from S_PICK to S_DONE. Free: one size-store read (S_FREE_RD,
// S_FREE_PUSH) before S_DONE; a full table goes straight to S_DONE. One request in flight;
// the next is taken once the result is registered, and S_DONE waits while the output stalls.
// rst_ni (async, low): empties the slot table, clears pages used, page_limit back to 16.
`include "best_fit_block_allocator_top_defines.svh"
module best_fit_block_allocator_top import bfa_pkg::*; #(
  parameter int unsigned PAGES        = PAGES_DEF,
  parameter int unsigned SLOTS        = SLOTS_DEF,
  parameter int unsigned HEADER_BYTES = HEADER_BYTES_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [31:0] s_axis_tdata_i,   // request_size[11:0], object_address[27:12]
  input  logic        s_axis_tuser_i,   // opcode[0]
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [23:0] m_axis_tdata_o,   // granted_address[15:0], status[17:16], page_claimed[18]
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int unsigned IW = $clog2(SLOTS);
  localparam int unsigned CW = $clog2(SLOTS+1);
  localparam int unsigned PW = $clog2(PAGES+1);
  localparam logic [SIZE_W-1:0] PAGE_SLOT = SIZE_W'(PAGE_BYTES - HEADER_BYTES);

  typedef enum logic [2:0] {
    S_IDLE, S_SCAN, S_PICK, S_PLACE, S_FREE_RD, S_FREE_PUSH, S_DONE
  } state_e;

  state_e             state_q;
  logic [CW-1:0]      count_q;
  logic [PW-1:0]      pages_q;
  logic [LIMIT_W-1:0] limit_q;
  logic [CW-1:0]      scan_q;
  logic [SIZE_W:0]    req_q;
  logic [ADDR_W-1:0]  hdr_q;
  logic [SIZE_W-1:0]  have_q;
  logic [ADDR_W-1:0]  res_addr_q;
  status_e            res_st_q;
  logic               res_clm_q;
  logic               out_valid_q;
  logic [23:0]        out_data_q;

  entry_t             entry   [SLOTS];
  cand_t              cand    [SLOTS];
  logic [IW-1:0]      cidx    [SLOTS];
  cell_ctrl_t         ctrl;
  entry_t             push_e;
  logic [IW-1:0]      rm_idx;

  logic               in_acc;
  logic [SIZE_W:0]    req_rnd;
  logic [SIZE_W:0]    req_raw;
  logic               no_page;
  logic [SIZE_W-1:0]  rest;
  logic [ADDR_W-1:0]  granted;
  logic               ram_we;
  logic [SIZE_W-1:0]  ram_rdata;
  cand_t              best;

  assign best    = cand[SLOTS-1];
  assign in_acc  = s_axis_tvalid_i && s_axis_tready_o;
  assign s_axis_tready_o = (state_q == S_IDLE);
  assign req_raw = {1'b0, s_axis_tdata_i[SIZE_W-1:0]} + (SIZE_W+1)'(7);
  assign req_rnd = (req_raw[SIZE_W:3] == '0) ? (SIZE_W+1)'(8) : {req_raw[SIZE_W:3], 3'b000};
  assign no_page = (req_q > (SIZE_W+1)'(PAGE_BYTES - HEADER_BYTES)) ||
                   (32'(pages_q) >= ((32'(limit_q) < PAGES) ? 32'(limit_q) : PAGES));
  assign rest    = have_q - req_q[SIZE_W-1:0];
  assign granted = hdr_q + ADDR_W'(HEADER_BYTES);

  always_comb begin
    ctrl   = '{remove: 1'b0, push: 1'b0};
    push_e = '{hdr: granted + ADDR_W'(req_q), size: rest - SIZE_W'(HEADER_BYTES)};
    rm_idx = cidx[SLOTS-1];
    ram_we = 1'b0;
    case (state_q)
      S_PICK:      ctrl.remove = best.found;
      S_PLACE: begin
        ram_we    = 1'b1;
        ctrl.push = rest > SIZE_W'(HEADER_BYTES);
      end
      S_FREE_PUSH: begin
        ctrl.push = 1'b1;
        push_e    = '{hdr: hdr_q, size: ram_rdata};
      end
      default: ;
    endcase
  end

  for (genvar g = 0; g < SLOTS; g++) begin : g_cell
    bfa_cell #(.SLOTS(SLOTS), .IDX(g)) u_cell (
      .clk_i    (clk_i),
      .ctrl_i   (ctrl),
      .rm_idx_i (rm_idx),
      .count_i  (count_q),
      .push_i   (push_e),
      .nbr_i    ((g == SLOTS-1) ? entry[g] : entry[(g+1) % SLOTS]),
      .req_i    (req_q),
      .cand_i   ((g == 0) ? cand_t'('0) : cand[(g+SLOTS-1) % SLOTS]),
      .cidx_i   ((g == 0) ? IW'(0) : cidx[(g+SLOTS-1) % SLOTS]),
      .entry_o  (entry[g]),
      .cand_o   (cand[g]),
      .cidx_o   (cidx[g])
    );
  end

  bfa_ram #(.WIDTH(SIZE_W), .DEPTH(STORE_DEPTH)) u_store (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .addr_i  (hdr_q[ADDR_W-1:3]),
    .wdata_i (req_q[SIZE_W-1:0]),
    .rdata_o (ram_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      count_q     <= '0;
      pages_q     <= '0;
      limit_q     <= LIMIT_RST;
      out_valid_q <= 1'b0;
    end else begin
      if (psel && penable && pwrite && (paddr == 3'd0)) begin
        limit_q <= pwdata[LIMIT_W-1:0];
      end
      if ((state_q == S_DONE) && (!out_valid_q || m_axis_tready_i)) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready_i) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        S_IDLE: begin
          if (in_acc) begin
            req_q     <= req_rnd;
            hdr_q     <= s_axis_tdata_i[SIZE_W +: ADDR_W] - ADDR_W'(HEADER_BYTES);
            res_addr_q <= '0;
            res_clm_q <= 1'b0;
            scan_q    <= CW'(SLOTS);
            if (s_axis_tuser_i == OP_FREE) begin
              if (count_q >= CW'(SLOTS)) begin
                res_st_q <= ST_TBL_FULL;
                state_q  <= S_DONE;
              end else begin
                res_st_q <= ST_OK;
                state_q  <= S_FREE_RD;
              end
            end else begin
              res_st_q <= ST_OK;
              state_q  <= S_SCAN;
            end
          end
        end
        S_SCAN: begin
          scan_q <= scan_q - CW'(1);
          if (scan_q == CW'(1)) begin
            state_q <= S_PICK;
          end
        end
        S_PICK: begin
          if (best.found) begin
            hdr_q   <= best.hdr;
            have_q  <= best.size;
            count_q <= count_q - CW'(1);
            state_q <= S_PLACE;
          end else if (no_page) begin
            res_st_q <= ST_NO_PAGE;
            state_q  <= S_DONE;
          end else if (count_q >= CW'(SLOTS)) begin
            res_st_q <= ST_TBL_FULL;
            state_q  <= S_DONE;
          end else begin
            hdr_q     <= ADDR_W'(32'(pages_q) << PAGE_SHIFT);
            have_q    <= PAGE_SLOT;
            pages_q   <= pages_q + PW'(1);
            res_clm_q <= 1'b1;
            state_q   <= S_PLACE;
          end
        end
        S_PLACE: begin
          res_addr_q <= granted;
          if (ctrl.push) begin
            count_q <= count_q + CW'(1);
          end
          state_q <= S_DONE;
        end
        S_FREE_RD:   state_q <= S_FREE_PUSH;
        S_FREE_PUSH: begin
          count_q <= count_q + CW'(1);
          state_q <= S_DONE;
        end
        S_DONE: begin
          if (!out_valid_q || m_axis_tready_i) begin
            out_data_q  <= {5'b0, res_clm_q, res_st_q, res_addr_q};
            state_q     <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = out_data_q;
  assign prdata          = {{(32-LIMIT_W){1'b0}}, limit_q};
  assign pready          = 1'b1;

  `BFA_ASSERT_ALWAYS(a_count_max, count_q <= CW'(SLOTS), "slot count above table size")
  `BFA_ASSERT_ALWAYS(a_pages_max, 32'(pages_q) <= PAGES, "pages used above page count")
  `BFA_ASSERT_IMPL(a_claim_ok, m_axis_tvalid_o && m_axis_tdata_o[18],
    m_axis_tdata_o[17:16] == ST_OK, "page claimed on a failed request")
  `BFA_ASSERT_NEXT(a_pick_place, state_q == S_PICK && best.found,
    state_q == S_PLACE && res_st_q == ST_OK, "found slot not placed")

endmodule
